// ===== rtl/bq_pkg.sv =====
// Shared types, widths and the control program of the biquad section.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package bq_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 32;
   localparam int FRAC_W    = 28;
   localparam int DELAY_W   = 48;
   localparam int Y_W       = DELAY_W + 1 - FRAC_W;   // rounded output before clamping
   localparam int MUL_A_W   = Y_W;                    // also holds a sign-extended sample
   localparam int PROD_W    = MUL_A_W + COEF_W;
   localparam int ACC_W     = PROD_W + 3;
   localparam int NUM_COEF  = 5;
   localparam int IDX_W     = 3;
   localparam int STEP_W    = 3;

   typedef enum logic [IDX_W-1:0] {
      COEF_FF0 = 3'd0,
      COEF_FF1 = 3'd1,
      COEF_FF2 = 3'd2,
      COEF_FB1 = 3'd3,
      COEF_FB2 = 3'd4
   } coef_sel_type;

   typedef enum logic [1:0] {
      MA_IN,
      MA_X,
      MA_Y
   } mul_a_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_P,
      ACC_P_PLUS_D1,
      ACC_P_PLUS_D2,
      ACC_MINUS_P
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_REQ,
      SEQ_WAIT_RSP,
      SEQ_JUMP
   } seq_type;

   typedef struct packed {
      seq_type              seq;
      logic [STEP_W-1:0]    target;
      logic                 mul_en;
      mul_a_type            mul_a;
      coef_sel_type         coef;
      acc_op_type           acc_op;
      logic                 wr_y;
      logic                 wr_d1;
      logic                 wr_d2;
   } ctrl_word_type;

   localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_ONE  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_OUT  = 3'd2;

   // Microprogram: one control word per step. The multiplier result is
   // registered, so a product issued in one step is consumed in the next.
   function automatic ctrl_word_type prog_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{seq: SEQ_NEXT, target: STEP_IDLE, mul_en: 1'b0, mul_a: MA_X,
            coef: COEF_FF0, acc_op: ACC_HOLD, wr_y: 1'b0, wr_d1: 1'b0, wr_d2: 1'b0};
      case (step)
         3'd0: begin
            w.seq = SEQ_WAIT_REQ; w.mul_en = 1'b1; w.mul_a = MA_IN; w.coef = COEF_FF0;
         end
         3'd1: begin
            w.acc_op = ACC_P_PLUS_D1; w.mul_en = 1'b1; w.mul_a = MA_X; w.coef = COEF_FF1;
         end
         3'd2: begin
            w.seq = SEQ_WAIT_RSP; w.wr_y = 1'b1; w.acc_op = ACC_P_PLUS_D2;
         end
         3'd3: begin
            w.mul_en = 1'b1; w.mul_a = MA_Y; w.coef = COEF_FB1;
         end
         3'd4: begin
            w.acc_op = ACC_MINUS_P; w.mul_en = 1'b1; w.mul_a = MA_X; w.coef = COEF_FF2;
         end
         3'd5: begin
            w.wr_d1 = 1'b1; w.acc_op = ACC_LOAD_P;
            w.mul_en = 1'b1; w.mul_a = MA_Y; w.coef = COEF_FB2;
         end
         3'd6: begin
            w.acc_op = ACC_MINUS_P;
         end
         3'd7: begin
            w.wr_d2 = 1'b1; w.seq = SEQ_JUMP; w.target = STEP_IDLE;
         end
         default: begin
            w.seq = SEQ_JUMP; w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Saturate the accumulator to the signed delay range.
   function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
      logic signed [DELAY_W-1:0] r;
      if (v[ACC_W-1:DELAY_W-1] == '0 || v[ACC_W-1:DELAY_W-1] == '1) begin
         r = v[DELAY_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(DELAY_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DELAY_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/biquad_iir_filter.sv =====
// Channel    Dir  Signals                              Contents
// request    in   req_tvalid/req_tready/req_tdata      sample_in [15:0]
// response   out  rsp_tvalid/rsp_tready/rsp_tdata/tuser sample_out [15:0], clipped in tuser
// csr        in   csr_wr_en/csr_index/csr_wr_data      coefficients a0 a1 a2 b1 b2
//
// Each request runs an eight-step microprogram that drives a single shared
// 21x32 multiplier and one accumulator, at most one product per step.
// The response is registered in step 2; the program waits there only if the
// previous response is still held. A new request is taken in step 0.
// Synchronous reset clears the delays, loads the default coefficients and
// returns the step counter to step 0. Depends on bq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [bq_pkg::SAMPLE_W-1:0]   req_tdata,    // [15:0] sample_in
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [bq_pkg::SAMPLE_W-1:0]   rsp_tdata,    // [15:0] sample_out
   output      logic                          rsp_tuser,    // [0] clipped
   input  wire logic                          csr_wr_en,
   input  wire logic [bq_pkg::IDX_W-1:0]      csr_index,
   input  wire logic [bq_pkg::COEF_W-1:0]     csr_wr_data
);
   import bq_pkg::*;

   localparam logic signed [COEF_W-1:0] A0_RESET = COEF_W'(1) <<< FRAC_W;
   localparam logic signed [DELAY_W:0]  RND_HALF = (DELAY_W+1)'(1) <<< (FRAC_W - 1);
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic [STEP_W-1:0]           step_ff, step_in;
   logic signed [COEF_W-1:0]    coef_ff [NUM_COEF];
   logic signed [SAMPLE_W-1:0]  x_ff, x_in;
   logic signed [Y_W-1:0]       y_ff, y_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [DELAY_W-1:0]   d1_ff, d1_in;
   logic signed [DELAY_W-1:0]   d2_ff, d2_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                        rsp_clip_ff, rsp_clip_in;

   ctrl_word_type               cw;
   logic                        step_go;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [COEF_W-1:0]    mul_b;
   logic signed [DELAY_W-1:0]   acc_sat;
   logic signed [DELAY_W:0]     rnd_sum;
   logic signed [Y_W-1:0]       y_new;
   logic                        y_over;
   logic signed [SAMPLE_W-1:0]  y_clamped;

   assign cw = prog_word(step_ff);

   always_comb begin
      case (cw.seq)
         SEQ_WAIT_REQ: step_go = req_tvalid;
         SEQ_WAIT_RSP: step_go = !rsp_valid_ff || rsp_tready;
         default:      step_go = 1'b1;
      endcase
   end

   always_comb begin
      case (cw.mul_a)
         MA_IN:   mul_a = MUL_A_W'(signed'(req_tdata));
         MA_X:    mul_a = MUL_A_W'(x_ff);
         MA_Y:    mul_a = y_ff;
         default: mul_a = '0;
      endcase
      mul_b = coef_ff[cw.coef];
   end

   // Saturate to the delay range, round half up, then clamp to the sample range.
   always_comb begin
      acc_sat = sat_delay(acc_ff);
      rnd_sum = (DELAY_W+1)'(acc_sat) + RND_HALF;
      y_new   = rnd_sum[DELAY_W:FRAC_W];
      y_over  = !(y_new[Y_W-1:SAMPLE_W-1] == '0 || y_new[Y_W-1:SAMPLE_W-1] == '1);
      if (!y_over) begin
         y_clamped = y_new[SAMPLE_W-1:0];
      end else if (y_new[Y_W-1]) begin
         y_clamped = OUT_MIN;
      end else begin
         y_clamped = OUT_MAX;
      end
   end

   always_comb begin
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      if (step_go) begin
         if (cw.seq == SEQ_JUMP) begin
            step_in = cw.target;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
         if (cw.seq == SEQ_WAIT_REQ) begin
            x_in = req_tdata;
         end
         if (cw.mul_en) begin
            prod_in = mul_a * mul_b;
         end
         case (cw.acc_op)
            ACC_LOAD_P:    acc_in = ACC_W'(prod_ff);
            ACC_P_PLUS_D1: acc_in = ACC_W'(prod_ff) + ACC_W'(d1_ff);
            ACC_P_PLUS_D2: acc_in = ACC_W'(prod_ff) + ACC_W'(d2_ff);
            ACC_MINUS_P:   acc_in = acc_ff - ACC_W'(prod_ff);
            default:       acc_in = acc_ff;
         endcase
         if (cw.wr_y) begin
            y_in         = y_new;
            rsp_valid_in = 1'b1;
            rsp_data_in  = y_clamped;
            rsp_clip_in  = y_over;
         end
         if (cw.wr_d1) begin
            d1_in = acc_sat;
         end
         if (cw.wr_d2) begin
            d2_in = acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         d1_ff        <= '0;
         d2_ff        <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
      end
   end

   // Writes to an index past the last coefficient are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[COEF_FF0] <= A0_RESET;
         coef_ff[COEF_FF1] <= '0;
         coef_ff[COEF_FF2] <= '0;
         coef_ff[COEF_FB1] <= '0;
         coef_ff[COEF_FB2] <= '0;
      end else if (csr_wr_en && (csr_index < IDX_W'(NUM_COEF))) begin
         coef_ff[csr_index] <= csr_wr_data;
      end
   end

   assign req_tready = (cw.seq == SEQ_WAIT_REQ);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clip_ff;

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (step_ff == STEP_ONE))
      else $error("accepted request did not start the program");

   a_rsp_from_out_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(step_ff) == STEP_OUT))
      else $error("response raised outside the output step");

   a_clip_is_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == OUT_MAX || rsp_tdata == OUT_MIN))
      else $error("clipped response not at a rail");
`endif

endmodule

`default_nettype wire
